// ===== rtl/core/wjos_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wjos_pkg
// shared types and constants of the weighted job order sorter
// ----------------------------------------------------------------------------
package wjos_pkg;

  localparam int unsigned MaxJobs = 64;   // capacity of the cell chain
  localparam int unsigned IdxW    = 6;    // job index inside the chain
  localparam int unsigned CntW    = 7;    // job count, holds MaxJobs itself
  localparam int unsigned TimeW   = 16;
  localparam int unsigned WeightW = 16;
  localparam int unsigned ProdW   = TimeW + WeightW;
  localparam int unsigned NumW    = 7;    // one-based job number

  // operands and arrival index of one stored job
  typedef struct packed {
    logic [IdxW-1:0]    idx;
    logic [TimeW-1:0]   tm;
    logic [WeightW-1:0] wt;
  } job_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic vld;
    job_t job;
  } entry_t;

  localparam entry_t EmptyEntry = '0;

  // per-cycle commands broadcast to every cell
  typedef struct packed {
    logic mul_en;   // form cross products against the new job
    logic ins_en;   // insert the new job, shifting toward the tail
    logic shl_en;   // shift toward the head while emitting
  } cell_ctrl_t;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StMul  = 4'b0010,
    StIns  = 4'b0100,
    StEmit = 4'b1000
  } state_e;

endpackage

// ===== rtl/core/wjos_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wjos_cell
// one slot of the sorted job chain with its own cross-product compare
// ----------------------------------------------------------------------------
module wjos_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wjos_pkg::cell_ctrl_t ctrl_i,
  input  wjos_pkg::job_t      new_job_i,
  input  wjos_pkg::entry_t    left_i,
  input  wjos_pkg::entry_t    right_i,
  input  logic                sfx_i,
  input  logic                sfx_left_i,
  output wjos_pkg::entry_t    ent_o,
  output logic                prec_o
);
  import wjos_pkg::*;

  logic              vld_q, vld_d;
  job_t              job_q, job_d;
  logic [ProdW-1:0]  lhs_q, rhs_q;

  always_comb begin
    vld_d = vld_q;
    job_d = job_q;
    if (ctrl_i.ins_en && sfx_i) begin
      if (!sfx_left_i) begin
        // first slot the new job strictly precedes everything from
        vld_d = 1'b1;
        job_d = new_job_i;
      end else begin
        vld_d = left_i.vld;
        job_d = left_i.job;
      end
    end else if (ctrl_i.shl_en) begin
      vld_d = right_i.vld;
      job_d = right_i.job;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    if (ctrl_i.mul_en) begin
      lhs_q <= ProdW'(new_job_i.wt) * ProdW'(job_q.tm);
      rhs_q <= ProdW'(new_job_i.tm) * ProdW'(job_q.wt);
    end
  end

  // empty slots never hold the new job back
  assign prec_o = !vld_q || (lhs_q > rhs_q);
  assign ent_o  = '{vld: vld_q, job: job_q};

endmodule

// ===== rtl/core/weighted_job_order_sorter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_job_order_sorter_unit
// weighted shortest processing time (smith's rule) job sorter
// ----------------------------------------------------------------------------
// Jobs arrive one per input transaction (time, weight, tlast = last job of the
// set) and are numbered 1, 2, ... in arrival order. They are kept sorted in a
// chain of 64 cells: job a goes ahead of job b when weight_a*time_b exceeds
// time_a*weight_b, ties keep the lower number first. A stored job is accepted,
// then cross products are formed in every cell, then it is compared and
// inserted by shifting the tail of the chain one cell on; a job beyond capacity
// is dropped and raises the dropped flag for the rest of the set. After the job
// marked tlast the chain shifts out from its head, one job number per cycle
// while the output side takes them, with tlast on the final number; the next
// input transaction is taken once the last number is in the output register.
// The output register lets the input side proceed while a result still waits.
// ----------------------------------------------------------------------------
module weighted_job_order_sorter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] job_time, [31:16] job_weight
  input  logic        s_axis_tlast,   // final_job
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [6:0] job_number, [7] zero
  output logic        m_axis_tlast,   // end_of_order
  output logic        m_axis_tuser    // dropped_jobs
);
  import wjos_pkg::*;

  state_e             state_q, state_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               ovf_q, ovf_d;
  logic               fin_q;
  job_t               new_q;

  logic               out_vld_q, out_vld_d;
  logic [NumW-1:0]    out_num_q;
  logic               out_end_q, out_drop_q;

  cell_ctrl_t         ctrl;
  entry_t             ent  [MaxJobs];
  logic [MaxJobs-1:0] prec;
  logic [MaxJobs-1:0] sfx;
  logic [MaxJobs-1:0] vld_vec;

  logic in_xfer;
  logic full;
  logic out_load;
  logic last_out;

  assign s_axis_tready = (state_q == StIdle);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign full          = (cnt_q == CntW'(MaxJobs));

  // head of the chain goes to the output register when it is free or drains
  assign out_load = (state_q == StEmit) && ent[0].vld && (!out_vld_q || m_axis_tready);
  assign last_out = !ent[1].vld;

  // suffix and: cell i is at or behind the insertion point when the new job
  // strictly precedes every occupied cell from i to the tail
  always_comb begin
    logic [MaxJobs-1:0] low_mask;
    low_mask = '0;
    for (int i = 0; i < MaxJobs; i++) begin
      low_mask = ~({MaxJobs{1'b1}} << i);
      sfx[i]   = &(prec | low_mask);
    end
  end

  always_comb begin
    ctrl.mul_en = (state_q == StMul);
    ctrl.ins_en = (state_q == StIns);
    ctrl.shl_en = out_load;
  end

  // next-state logic
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;
    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          if (full) begin
            // no room left: drop the job, remember it for this set
            ovf_d = 1'b1;
            if (s_axis_tlast) begin
              state_d = StEmit;
            end
          end else begin
            state_d = StMul;
          end
        end
      end
      StMul: begin
        state_d = StIns;
      end
      StIns: begin
        cnt_d   = cnt_q + CntW'(1);
        state_d = fin_q ? StEmit : StIdle;
      end
      StEmit: begin
        if (out_load && last_out) begin
          // final number is latched: the set is done
          state_d = StIdle;
          cnt_d   = '0;
          ovf_d   = 1'b0;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      ovf_q     <= ovf_d;
      out_vld_q <= out_vld_d;
    end
  end

  // incoming job payload, numbered by its arrival slot
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      new_q.tm <= s_axis_tdata[TimeW-1:0];
      new_q.wt <= s_axis_tdata[TimeW+WeightW-1:TimeW];
      new_q.idx <= cnt_q[IdxW-1:0];
      fin_q    <= s_axis_tlast;
    end
    if (out_load) begin
      out_num_q  <= NumW'(ent[0].job.idx) + NumW'(1);
      out_end_q  <= last_out;
      out_drop_q <= ovf_q;
    end
  end

  // chain of cells, head at index 0
  for (genvar g = 0; g < MaxJobs; g++) begin : g_cell
    entry_t left_ent, right_ent;
    logic   sfx_left;

    if (g == 0) begin : g_head
      assign left_ent = EmptyEntry;
      assign sfx_left = 1'b0;
    end else begin : g_mid
      assign left_ent = ent[g-1];
      assign sfx_left = sfx[g-1];
    end

    if (g == MaxJobs - 1) begin : g_tail
      assign right_ent = EmptyEntry;
    end else begin : g_body
      assign right_ent = ent[g+1];
    end

    wjos_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .new_job_i  (new_q),
      .left_i     (left_ent),
      .right_i    (right_ent),
      .sfx_i      (sfx[g]),
      .sfx_left_i (sfx_left),
      .ent_o      (ent[g]),
      .prec_o     (prec[g])
    );

    assign vld_vec[g] = ent[g].vld;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, out_num_q};
  assign m_axis_tlast  = out_end_q;
  assign m_axis_tuser  = out_drop_q;

`ifndef ASSERT_OFF
  // occupied cells always form an unbroken run from the head
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({1'b0, vld_vec} + (MaxJobs + 1)'(1)))
    else $error("chain has a gap between occupied cells");

  // between items the occupied cells match the job count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> ($countones(vld_vec) == int'(cnt_q)))
    else $error("occupied cells disagree with job count");

  // the count never passes capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxJobs))
    else $error("job count beyond capacity");

  // once the final number is latched the chain is empty and input reopens
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && last_out) |=> (state_q == StIdle) && !ent[0].vld && m_axis_tlast)
    else $error("set not closed after final job number");
`endif

endmodule
